/* hw/rtl/rase_pkg.sv */
`default_nettype none
package rase_pkg;

  localparam int unsigned NUM_REGS    = 16;
  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned RIDX_W      = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int unsigned SADDR_W     = $clog2(STACK_DEPTH);
  localparam int unsigned SP_W        = $clog2(STACK_DEPTH + 1);

  localparam logic [7:0] IMM_SELECT = 8'hFF;

  typedef enum logic [2:0] {
    CMD_ADD  = 3'd0,
    CMD_SUB  = 3'd1,
    CMD_MUL  = 3'd2,
    CMD_DIV  = 3'd3,
    CMD_MOD  = 3'd4,
    CMD_MOV  = 3'd5,
    CMD_PUSH = 3'd6,
    CMD_POP  = 3'd7
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_RANGE   = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_STACK   = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [7:0]         dest_reg;
    logic [7:0]         src_reg;
    logic signed [31:0] immediate;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] dest_value;
    logic [8:0]         stack_depth;
  } rsp_t;

  typedef struct packed {
    logic        start;
    logic        is_mod;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] result;
  } div_rsp_t;

endpackage
`default_nettype wire

/* hw/rtl/rase_divider.sv */
`default_nettype none
module rase_divider
  import rase_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire div_req_t req_i,
  output div_rsp_t      rsp_o
);

  // restoring divider on magnitudes, one quotient bit per cycle
  logic [31:0] rem_q, rem_d, quo_q, quo_d, dvs_q, dvs_d;
  logic [5:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d, done_q, done_d;
  logic        negq_q, negq_d, negr_q, negr_d, mod_q, mod_d;
  logic [32:0] trial;
  logic [31:0] shifted;
  logic [31:0] res;

  always_comb begin
    shifted = {rem_q[30:0], quo_q[31]};
    trial   = {1'b0, shifted} - {1'b0, dvs_q};
    rem_d = rem_q; quo_d = quo_q; dvs_d = dvs_q; cnt_d = cnt_q;
    busy_d = busy_q; done_d = 1'b0;
    negq_d = negq_q; negr_d = negr_q; mod_d = mod_q;
    if (req_i.start) begin
      rem_d  = '0;
      quo_d  = req_i.dividend[31] ? (32'd0 - req_i.dividend) : req_i.dividend;
      dvs_d  = req_i.divisor[31] ? (32'd0 - req_i.divisor) : req_i.divisor;
      negq_d = req_i.dividend[31] ^ req_i.divisor[31];
      negr_d = req_i.dividend[31];
      mod_d  = req_i.is_mod;
      cnt_d  = 6'd0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (!trial[32]) begin
        rem_d = trial[31:0];
        quo_d = {quo_q[30:0], 1'b1};
      end else begin
        rem_d = shifted;
        quo_d = {quo_q[30:0], 1'b0};
      end
      cnt_d = cnt_q + 6'd1;
      if (cnt_q == 6'd31) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; quo_q <= quo_d; dvs_q <= dvs_d;
    negq_q <= negq_d; negr_q <= negr_d; mod_q <= mod_d;
  end

  always_comb begin
    if (mod_q) res = negr_q ? (32'd0 - rem_q) : rem_q;
    else       res = negq_q ? (32'd0 - quo_q) : quo_q;
  end

  assign rsp_o.done   = done_q;
  assign rsp_o.result = res;

endmodule
`default_nettype wire

/* hw/rtl/rase_stack.sv */
`default_nettype none
module rase_stack
  import rase_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               we_i,
  input  wire logic [SADDR_W-1:0] waddr_i,
  input  wire logic [31:0]        wdata_i,
  input  wire logic [SADDR_W-1:0] raddr_i,
  output logic [31:0]             rdata_o
);

  logic [31:0] mem [STACK_DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) mem[waddr_i] <= wdata_i;
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

/* hw/rtl/register_alu_stack_executor.sv */
`default_nettype none
// Channel  | Direction | Handshake              | Payload
// request  | in        | req_valid_i/req_ready_o | req_i (cmd, dest_reg, src_reg, immediate)
// response | out       | rsp_valid_o/rsp_ready_i | rsp_o (status, dest_value, stack_depth)
//
// One request at a time. Add/sub/mov/push, errors and div/mod by -1 go from S_EXEC
// to S_RESP; mul passes S_MUL, pop S_POP, div/mod wait in S_DIV on the shared
// 1 bit per cycle restoring divider. Ready drops after accept and returns once the
// response is taken. Reset clears the register file, stack pointer and control;
// stack memory is not cleared. A stalled response holds in the output register.
module register_alu_stack_executor
  import rase_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic req_valid_i,
  output logic      req_ready_o,
  input  wire req_t req_i,
  output logic      rsp_valid_o,
  input  wire logic rsp_ready_i,
  output rsp_t      rsp_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;  // operands registered, decide
  localparam logic [2:0] S_MUL  = 3'd2;  // product registered
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_POP  = 3'd4;  // stack read data landing
  localparam logic [2:0] S_RESP = 3'd5;

  logic [2:0]  state_q, state_d;
  req_t        cur_q;
  logic [31:0] a_q, b_q, prod_q;
  logic        badsrc_q;
  logic [31:0] regs_q [NUM_REGS];
  logic [SP_W-1:0] sp_q, sp_d;
  rsp_t        rsp_q, rsp_d;

  logic        rf_we;
  logic [31:0] rf_wdata;
  logic        st_we;
  logic [31:0] st_rdata;
  div_req_t    dreq;
  div_rsp_t    drsp;

  logic [RIDX_W-1:0] didx;
  assign didx = cur_q.dest_reg[RIDX_W-1:0];

  logic [SP_W-1:0] sp_m1;
  assign sp_m1 = sp_q - SP_W'(1);

  rase_stack u_stack (
    .clk_i,
    .we_i   (st_we),
    .waddr_i(sp_q[SADDR_W-1:0]),
    .wdata_i(a_q),
    .raddr_i(sp_m1[SADDR_W-1:0]),
    .rdata_o(st_rdata)
  );

  rase_divider u_div (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = (state_q == S_RESP);
  assign rsp_o       = rsp_q;

  function automatic rsp_t mk(input status_e st, input logic [31:0] v,
                              input logic [SP_W-1:0] sp);
    rsp_t r;
    r.status      = st;
    r.dest_value  = v;
    r.stack_depth = 9'(sp);
    return r;
  endfunction

  always_comb begin
    state_d = state_q; sp_d = sp_q; rsp_d = rsp_q;
    rf_we = 1'b0; rf_wdata = '0; st_we = 1'b0;
    dreq.start = 1'b0;
    dreq.is_mod = (cur_q.cmd == CMD_MOD);
    dreq.dividend = a_q;
    dreq.divisor = b_q;
    unique case (state_q)
      S_IDLE: if (req_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        state_d = S_RESP;
        if (32'(cur_q.dest_reg) >= NUM_REGS) begin
          rsp_d = mk(ST_RANGE, '0, sp_q);
        end else if (cur_q.cmd == CMD_PUSH) begin
          if (32'(sp_q) >= STACK_DEPTH) rsp_d = mk(ST_STACK, '0, sp_q);
          else begin
            st_we = 1'b1;
            sp_d  = sp_q + SP_W'(1);
            rsp_d = mk(ST_OK, a_q, sp_d);
          end
        end else if (cur_q.cmd == CMD_POP) begin
          if (sp_q == '0) rsp_d = mk(ST_STACK, '0, sp_q);
          else begin
            sp_d = sp_m1;
            state_d = S_POP;
          end
        end else if (badsrc_q) begin
          rsp_d = mk(ST_RANGE, '0, sp_q);
        end else begin
          unique case (cur_q.cmd)
            CMD_ADD: begin
              rf_we = 1'b1; rf_wdata = a_q + b_q;
              rsp_d = mk(ST_OK, rf_wdata, sp_q);
            end
            CMD_SUB: begin
              rf_we = 1'b1; rf_wdata = a_q - b_q;
              rsp_d = mk(ST_OK, rf_wdata, sp_q);
            end
            CMD_MUL: state_d = S_MUL;
            CMD_DIV, CMD_MOD: begin
              if (b_q == '0) rsp_d = mk(ST_DIVZERO, '0, sp_q);
              else if (b_q == 32'hFFFF_FFFF) begin
                rf_we = 1'b1;
                rf_wdata = (cur_q.cmd == CMD_DIV) ? (32'd0 - a_q) : 32'd0;
                rsp_d = mk(ST_OK, rf_wdata, sp_q);
              end else begin
                dreq.start = 1'b1;
                state_d = S_DIV;
              end
            end
            default: begin
              rf_we = 1'b1; rf_wdata = b_q;
              rsp_d = mk(ST_OK, rf_wdata, sp_q);
            end
          endcase
        end
      end
      S_MUL: begin
        rf_we = 1'b1; rf_wdata = prod_q;
        rsp_d = mk(ST_OK, prod_q, sp_q);
        state_d = S_RESP;
      end
      S_DIV: if (drsp.done) begin
        rf_we = 1'b1; rf_wdata = drsp.result;
        rsp_d = mk(ST_OK, drsp.result, sp_q);
        state_d = S_RESP;
      end
      S_POP: begin
        rf_we = 1'b1; rf_wdata = st_rdata;
        rsp_d = mk(ST_OK, st_rdata, sp_q);
        state_d = S_RESP;
      end
      S_RESP: if (rsp_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_q    <= '0;
      for (int i = 0; i < NUM_REGS; i++) regs_q[i] <= '0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      if (rf_we) regs_q[didx] <= rf_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_q  <= rsp_d;
    prod_q <= a_q * b_q;
    if (req_valid_i && req_ready_o) begin
      cur_q <= req_i;
      // index check against the incoming fields; reads use them directly
      a_q <= (32'(req_i.dest_reg) < NUM_REGS) ? regs_q[req_i.dest_reg[RIDX_W-1:0]] : '0;
      if (req_i.src_reg == IMM_SELECT) b_q <= req_i.immediate;
      else if (32'(req_i.src_reg) < NUM_REGS) b_q <= regs_q[req_i.src_reg[RIDX_W-1:0]];
      else b_q <= '0;
      badsrc_q <= (req_i.src_reg != IMM_SELECT) && (32'(req_i.src_reg) >= NUM_REGS);
    end
  end

endmodule
`default_nettype wire

/* test/testbench.sv */
`default_nettype none
module testbench;
  import rase_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic req_valid_i = 1'b0;
  logic req_ready_o;
  req_t req_i = '0;
  logic rsp_valid_o;
  logic rsp_ready_i = 1'b0;
  rsp_t rsp_o;

  always #5 clk_i = ~clk_i;

  register_alu_stack_executor dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .req_valid_i(req_valid_i),
    .req_ready_o(req_ready_o),
    .req_i(req_i),
    .rsp_valid_o(rsp_valid_o),
    .rsp_ready_i(rsp_ready_i),
    .rsp_o(rsp_o)
  );

  // Shadow machine state, updated as each request is accepted.
  logic [31:0] regs_q [NUM_REGS];
  logic [31:0] stack_mem_q [STACK_DEPTH];
  int unsigned sp_q;

  rsp_t pending_rsp_q [$];
  int unsigned errors;
  int unsigned cycles;
  bit hold_rsp;   // long receiver stall while the sender keeps going

  // Compute the response of one instruction and advance the shadow state.
  function automatic rsp_t execute_instr(req_t rq);
    rsp_t rs;
    logic [31:0] a, b, r;
    int signed sa, sb;
    rs = '0;
    if (rq.dest_reg >= NUM_REGS) begin
      rs.status = ST_RANGE;
      rs.stack_depth = sp_q[8:0];
      return rs;
    end
    if (rq.cmd == CMD_PUSH) begin
      if (sp_q >= STACK_DEPTH) begin
        rs.status = ST_STACK;
      end else begin
        stack_mem_q[sp_q] = regs_q[rq.dest_reg];
        sp_q++;
        rs.status = ST_OK;
        rs.dest_value = regs_q[rq.dest_reg];
      end
      rs.stack_depth = sp_q[8:0];
      return rs;
    end
    if (rq.cmd == CMD_POP) begin
      if (sp_q == 0) begin
        rs.status = ST_STACK;
      end else begin
        sp_q--;
        regs_q[rq.dest_reg] = stack_mem_q[sp_q];
        rs.status = ST_OK;
        rs.dest_value = regs_q[rq.dest_reg];
      end
      rs.stack_depth = sp_q[8:0];
      return rs;
    end
    rs.stack_depth = sp_q[8:0];
    if (rq.src_reg == IMM_SELECT) begin
      b = rq.immediate;
    end else if (rq.src_reg >= NUM_REGS) begin
      rs.status = ST_RANGE;
      return rs;
    end else begin
      b = regs_q[rq.src_reg];
    end
    a = regs_q[rq.dest_reg];
    case (rq.cmd)
      CMD_ADD: r = a + b;
      CMD_SUB: r = a - b;
      CMD_MUL: r = a * b;
      CMD_DIV, CMD_MOD: begin
        if (b == 0) begin
          rs.status = ST_DIVZERO;
          return rs;
        end
        if (b == 32'hFFFF_FFFF) begin
          // x / -1 negates (INT_MIN wraps to itself), remainder always 0
          r = (rq.cmd == CMD_DIV) ? (32'd0 - a) : 32'd0;
        end else begin
          sa = a;
          sb = b;
          r = (rq.cmd == CMD_DIV) ? sa / sb : sa % sb;
        end
      end
      default: r = b;
    endcase
    regs_q[rq.dest_reg] = r;
    rs.status = ST_OK;
    rs.dest_value = r;
    return rs;
  endfunction

  function automatic req_t mk_req(cmd_e c, int unsigned d, int unsigned s, logic [31:0] imm);
    req_t rq;
    rq.cmd = c;
    rq.dest_reg = d[7:0];
    rq.src_reg = s[7:0];
    rq.immediate = imm;
    return rq;
  endfunction

  // Random instruction: mostly valid register indexes, some out-of-range,
  // biased immediates so that zero, -1 and INT_MIN show up often.
  function automatic req_t rand_req();
    req_t rq;
    int unsigned pick;
    rq.cmd = 3'($urandom_range(7, 0));
    rq.dest_reg = ($urandom_range(19, 0) == 0) ? 8'($urandom_range(255, 0))
                                               : 8'($urandom_range(NUM_REGS - 1, 0));
    pick = $urandom_range(9, 0);
    if (pick < 4) rq.src_reg = IMM_SELECT;
    else if (pick == 4) rq.src_reg = 8'($urandom_range(254, 0));
    else rq.src_reg = 8'($urandom_range(NUM_REGS - 1, 0));
    pick = $urandom_range(7, 0);
    case (pick)
      0: rq.immediate = 32'd0;
      1: rq.immediate = 32'hFFFF_FFFF;
      2: rq.immediate = 32'h8000_0000;
      3: rq.immediate = 32'h7FFF_FFFF;
      4: rq.immediate = $urandom_range(15, 0) - 8;
      default: rq.immediate = $urandom;
    endcase
    return rq;
  endfunction

  // Directed table: request plus a hand-typed response where obvious.
  typedef struct {
    req_t rq;
    bit known;
    rsp_t rs;
  } dir_row_t;
  dir_row_t dir_rows [$];

  task automatic add_row(req_t rq, bit known = 0, status_e st = ST_OK,
                         logic [31:0] val = 0, int unsigned depth = 0);
    dir_row_t row;
    row.rq = rq;
    row.known = known;
    row.rs.status = st;
    row.rs.dest_value = val;
    row.rs.stack_depth = depth[8:0];
    dir_rows.push_back(row);
  endtask

  // Valid drops only when a gap is drawn; with no gap the next request
  // follows directly, and wait_drained drops valid before any pause.
  task automatic send_req(req_t rq, bit known, rsp_t typed);
    rsp_t exp_rsp;
    int unsigned gap;
    gap = $urandom_range(11, 0);
    if (gap != 0) begin
      req_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_i <= rq;
    req_valid_i <= 1'b1;
    do @(posedge clk_i); while (!req_ready_o);
    exp_rsp = execute_instr(rq);
    if (known && exp_rsp !== typed) begin
      $display("%0t table row mismatch: expected %p actual %p", $time, typed, exp_rsp);
      errors++;
    end
    pending_rsp_q.push_back(exp_rsp);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    req_valid_i <= 1'b0;
    while (pending_rsp_q.size() != 0) @(negedge clk_i);
  endtask

  // Receiver: random ready gaps, plus one long hold when asked.
  initial begin
    int unsigned gap;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rsp) begin
        rsp_ready_i <= 1'b0;
        repeat (300) @(negedge clk_i);
        hold_rsp = 0;
      end
      gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(11, 0);
      if (gap != 0) begin
        rsp_ready_i <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      rsp_ready_i <= 1'b1;
      do @(posedge clk_i); while (!rsp_valid_o);
    end
  end

  // Response checker.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o && rsp_ready_i) begin
      if (pending_rsp_q.size() == 0) begin
        $display("%0t unexpected response: expected none actual %p", $time, rsp_o);
        errors++;
      end else begin
        rsp_t e;
        e = pending_rsp_q.pop_front();
        if (rsp_o.status !== e.status)
          $display("%0t status: expected %0d actual %0d", $time, e.status, rsp_o.status);
        if (rsp_o.dest_value !== e.dest_value)
          $display("%0t dest_value: expected %0d actual %0d", $time, e.dest_value,
                   rsp_o.dest_value);
        if (rsp_o.stack_depth !== e.stack_depth)
          $display("%0t stack_depth: expected %0d actual %0d", $time, e.stack_depth,
                   rsp_o.stack_depth);
        if (rsp_o !== e) errors++;
      end
    end
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    rsp_t none;
    req_t rq;
    int unsigned burst;
    none = '0;
    errors = 0;
    cycles = 0;
    hold_rsp = 0;
    sp_q = 0;
    foreach (regs_q[i]) regs_q[i] = '0;
    foreach (stack_mem_q[i]) stack_mem_q[i] = '0;

    // After reset: registers zero, stack empty.
    add_row(mk_req(CMD_POP, 0, 0, 0), 1, ST_STACK, 0, 0);
    add_row(mk_req(CMD_ADD, 16, 0, 0), 1, ST_RANGE, 0, 0);
    add_row(mk_req(CMD_PUSH, 255, 0, 0), 1, ST_RANGE, 0, 0);
    add_row(mk_req(CMD_ADD, 0, 16, 0), 1, ST_RANGE, 0, 0);
    add_row(mk_req(CMD_MOV, 1, 254, 0), 1, ST_RANGE, 0, 0);
    add_row(mk_req(CMD_DIV, 0, 1, 0), 1, ST_DIVZERO, 0, 0);
    add_row(mk_req(CMD_MOD, 0, IMM_SELECT, 0), 1, ST_DIVZERO, 0, 0);
    add_row(mk_req(CMD_MOV, 1, IMM_SELECT, 32'h8000_0000), 1, ST_OK, 32'h8000_0000, 0);
    add_row(mk_req(CMD_MOV, 2, IMM_SELECT, 32'hFFFF_FFFF), 1, ST_OK, 32'hFFFF_FFFF, 0);
    add_row(mk_req(CMD_MOV, 3, 1, 0), 1, ST_OK, 32'h8000_0000, 0);
    add_row(mk_req(CMD_DIV, 1, 2, 0), 1, ST_OK, 32'h8000_0000, 0);
    add_row(mk_req(CMD_MOD, 3, IMM_SELECT, 32'hFFFF_FFFF), 1, ST_OK, 0, 0);
    add_row(mk_req(CMD_ADD, 15, IMM_SELECT, 32'h7FFF_FFFF), 1, ST_OK, 32'h7FFF_FFFF, 0);
    add_row(mk_req(CMD_ADD, 15, IMM_SELECT, 1), 1, ST_OK, 32'h8000_0000, 0);
    add_row(mk_req(CMD_SUB, 15, IMM_SELECT, 1), 1, ST_OK, 32'h7FFF_FFFF, 0);
    add_row(mk_req(CMD_MUL, 15, 15, 0));
    add_row(mk_req(CMD_MOV, 4, IMM_SELECT, -7));
    add_row(mk_req(CMD_DIV, 4, IMM_SELECT, 2));
    add_row(mk_req(CMD_MOV, 5, IMM_SELECT, -7));
    add_row(mk_req(CMD_MOD, 5, IMM_SELECT, 2));
    add_row(mk_req(CMD_PUSH, 15, 0, 0), 1, ST_OK, 32'h0000_0001, 1);
    add_row(mk_req(CMD_POP, 6, 0, 0), 1, ST_OK, 32'h0000_0001, 0);

    req_i <= '0;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) send_req(dir_rows[i].rq, dir_rows[i].known, dir_rows[i].rs);

    // Fill the stack to the top, then two pushes too many, while the receiver
    // holds off for a long stretch.
    hold_rsp = 1;
    for (int unsigned k = sp_q; k < STACK_DEPTH + 2; k++)
      send_req(mk_req(CMD_PUSH, $urandom_range(NUM_REGS - 1, 0), $urandom, $urandom), 0, none);

    // Sender pause until everything is back.
    wait_drained();

    // Drain the stack completely and one pop past empty.
    for (int unsigned k = 0; k < STACK_DEPTH + 1; k++)
      send_req(mk_req(CMD_POP, $urandom_range(NUM_REGS - 1, 0), $urandom, $urandom), 0, none);

    // Random instruction stream.
    for (int unsigned n = 0; n < 500; n++) begin
      rq = rand_req();
      send_req(rq, 0, none);
    end

    // Push/pop bursts with random content to move the stack pointer around.
    for (int unsigned n = 0; n < 20; n++) begin
      burst = $urandom_range(8, 1);
      repeat (burst) send_req(mk_req(($urandom_range(2, 0) != 0) ? CMD_PUSH : CMD_POP,
                                     $urandom_range(NUM_REGS - 1, 0), 0, 0), 0, none);
    end

    wait_drained();
    repeat (60) @(negedge clk_i);
    if (errors == 0 && pending_rsp_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
